// ===== hdl/cswq_pkg.sv =====
// Shared constants, types and helpers for the semaphore wait-queue block.
package cswq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int RES_W   = $clog2(MAX_RESULTS + 1);
  localparam int COUNT_W = 16;
  localparam int TASK_W  = 8;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

  localparam logic [1:0] OP_DOWN    = 2'd0;
  localparam logic [1:0] OP_UP      = 2'd1;
  localparam logic [1:0] OP_DESTROY = 2'd2;
  localparam logic [1:0] OP_REINIT  = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DEAD  = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;
  localparam logic [1:0] STATUS_ALIVE = 2'd3;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic [1:0]               status;
    logic                     blocked;
    logic                     woke_valid;
    logic [TASK_W-1:0]        woke_task;
    logic signed [COUNT_W-1:0] count_now;
    logic                     last;
  } result_t;

  function automatic ptr_t next_ptr(input ptr_t p);
    next_ptr = (32'(p) + 1 >= QUEUE_DEPTH) ? '0 : p + 1'b1;
  endfunction

endpackage

// ===== hdl/counting_semaphore_wait_queue.sv =====
// Top level: counting semaphore with a FIFO wait queue held in a small RAM.
//
// Input channel (in_valid/in_stall) carries one operation and a task id per beat;
// output channel (out_valid/out_stall) carries result beats from an output register.
// initial_count is written through cfg_wen/cfg_wdata; the user must do so only while the
// block is idle, as the block itself does not enforce it.
// Down, reinit and non-releasing up produce their single beat at the clock edge that
// takes the input, so a new input can be taken every cycle while the output drains.
// An up that releases a waiter reads the head entry from the waiter RAM (registered read
// port); its beat is pushed once that data is valid and the output register is free.
// Destroy releases all waiters: after the head entry is read from the waiter RAM, one
// beat goes out per cycle while the output register is free (RAM read port pace);
// with no waiters, or when already destroyed, destroy gives its one beat at once.
// Input is held off (in_stall high) while waiters are being released or while the
// output register holds a beat the receiver is stalling.
// Reset (rst, synchronous) empties the queue, clears the count and the dead flag and
// sets initial_count to zero. RAM contents are not cleared; unread entries never matter.
module counting_semaphore_wait_queue
  import cswq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [7:0]                cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                operation,
  input  logic [TASK_W-1:0]         task_id,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic                      blocked,
  output logic                      woke_valid,
  output logic [TASK_W-1:0]         woke_task,
  output logic signed [COUNT_W-1:0] count_now,
  output logic                      last
);

  localparam logic ST_IDLE    = 1'b0;
  localparam logic ST_RELEASE = 1'b1;

  logic                      state, state_next;
  logic [7:0]                initial_count;
  logic signed [COUNT_W-1:0] count, count_next;
  ptr_t                      head_ptr, head_ptr_next;
  ptr_t                      tail_ptr, tail_ptr_next;
  logic [OCC_W-1:0]          occupancy, occupancy_next;
  logic                      dead, dead_next;
  logic [RES_W-1:0]          remain, remain_next;
  logic                      drain_all, drain_all_next;
  logic                      data_ok, data_ok_next;

  logic                      slot_free;
  logic                      accept;
  logic                      fire;
  logic                      push;
  result_t                   push_data;
  result_t                   out_data;
  logic                      ram_we;
  logic                      ram_re;
  ptr_t                      ram_raddr;
  logic [TASK_W-1:0]         ram_rdata;
  logic signed [COUNT_W-1:0] count_up;

  assign in_stall = !((state == ST_IDLE) && slot_free);
  assign accept   = in_valid && !in_stall;
  assign fire     = (state == ST_RELEASE) && data_ok && slot_free;
  assign count_up = (count < COUNT_MAX) ? count + 16'sd1 : count;

  // Keep reading the head; step ahead on a released beat so data stays one entry ahead.
  assign ram_re    = (state == ST_RELEASE);
  assign ram_raddr = fire ? next_ptr(head_ptr) : head_ptr;

  always_comb begin
    state_next     = state;
    count_next     = count;
    head_ptr_next  = head_ptr;
    tail_ptr_next  = tail_ptr;
    occupancy_next = occupancy;
    dead_next      = dead;
    remain_next    = remain;
    drain_all_next = drain_all;
    data_ok_next   = 1'b0;
    ram_we         = 1'b0;
    push           = 1'b0;
    push_data      = '{status: STATUS_OK, blocked: 1'b0, woke_valid: 1'b0,
                       woke_task: '0, count_now: count, last: 1'b1};
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          push = 1'b1;
          unique case (operation)
            OP_DOWN: begin
              if (dead) begin
                push_data.status = STATUS_DEAD;
              end else if (count <= 16'sd0) begin
                if (32'(occupancy) >= QUEUE_DEPTH || count == COUNT_MIN) begin
                  push_data.status = STATUS_FULL;
                end else begin
                  count_next          = count - 16'sd1;
                  ram_we              = 1'b1;
                  tail_ptr_next       = next_ptr(tail_ptr);
                  occupancy_next      = occupancy + 1'b1;
                  push_data.blocked   = 1'b1;
                  push_data.count_now = count - 16'sd1;
                end
              end else begin
                count_next          = count - 16'sd1;
                push_data.count_now = count - 16'sd1;
              end
            end
            OP_UP: begin
              if (dead) begin
                push_data.status = STATUS_DEAD;
              end else begin
                count_next = count_up;
                if (count_up <= 16'sd0 && occupancy != '0) begin
                  // hold the beat until the head entry is read
                  push           = 1'b0;
                  state_next     = ST_RELEASE;
                  remain_next    = RES_W'(1);
                  drain_all_next = 1'b0;
                end else begin
                  push_data.count_now = count_up;
                end
              end
            end
            OP_DESTROY: begin
              if (dead) begin
                push_data.status = STATUS_DEAD;
              end else begin
                dead_next = 1'b1;
                if (occupancy == '0) begin
                  head_ptr_next = '0;
                  tail_ptr_next = '0;
                end else begin
                  push           = 1'b0;
                  state_next     = ST_RELEASE;
                  drain_all_next = 1'b1;
                  remain_next    = (32'(occupancy) > MAX_RESULTS) ? RES_W'(MAX_RESULTS)
                                                                  : RES_W'(occupancy);
                end
              end
            end
            OP_REINIT: begin
              if (!dead) begin
                push_data.status = STATUS_ALIVE;
              end else begin
                count_next          = $signed({8'h00, initial_count});
                dead_next           = 1'b0;
                head_ptr_next       = '0;
                tail_ptr_next       = '0;
                occupancy_next      = '0;
                push_data.count_now = $signed({8'h00, initial_count});
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RELEASE: begin
        data_ok_next = 1'b1;
        if (fire) begin
          push                 = 1'b1;
          push_data.woke_valid = 1'b1;
          push_data.woke_task  = ram_rdata;
          push_data.last       = (remain == RES_W'(1));
          head_ptr_next        = next_ptr(head_ptr);
          occupancy_next       = occupancy - 1'b1;
          remain_next          = remain - 1'b1;
          if (remain == RES_W'(1)) begin
            state_next   = ST_IDLE;
            data_ok_next = 1'b0;
            if (drain_all) begin
              // drop any waiters past the result limit
              head_ptr_next  = '0;
              tail_ptr_next  = '0;
              occupancy_next = '0;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      initial_count <= '0;
      count         <= '0;
      head_ptr      <= '0;
      tail_ptr      <= '0;
      occupancy     <= '0;
      dead          <= 1'b0;
      remain        <= '0;
      drain_all     <= 1'b0;
      data_ok       <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      head_ptr  <= head_ptr_next;
      tail_ptr  <= tail_ptr_next;
      occupancy <= occupancy_next;
      dead      <= dead_next;
      remain    <= remain_next;
      drain_all <= drain_all_next;
      data_ok   <= data_ok_next;
      if (cfg_wen) begin
        initial_count <= cfg_wdata;
      end
    end
  end

  cswq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (TASK_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (tail_ptr),
    .wr_data (task_id),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  cswq_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_data),
    .stall (out_stall),
    .valid (out_valid),
    .dout  (out_data),
    .free  (slot_free)
  );

  assign status     = out_data.status;
  assign blocked    = out_data.blocked;
  assign woke_valid = out_data.woke_valid;
  assign woke_task  = out_data.woke_task;
  assign count_now  = out_data.count_now;
  assign last       = out_data.last;

  a_push_has_slot: assert property (@(posedge clk) disable iff (rst)
    push |-> slot_free)
    else $error("result pushed while output register is occupied and stalled");

  a_release_remain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RELEASE) |-> (remain != '0) && (occupancy != '0))
    else $error("release in progress with nothing left to release");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (fire && drain_all && remain == RES_W'(1)) |=> (occupancy == '0) && dead
      && (state == ST_IDLE))
    else $error("queue not empty after destroy drain");

  a_woke_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && woke_valid) |-> (status == STATUS_OK) && !blocked)
    else $error("released task reported with error status");

endmodule

// ===== hdl/cswq_ram.sv =====
// Simple dual-port waiter RAM: one write port, one registered read port.
module cswq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/cswq_out_reg.sv =====
// Output register for result beats; frees its slot in the cycle a beat is taken.
module cswq_out_reg
  import cswq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t din,
  input  logic    stall,
  output logic    valid,
  output result_t dout,
  output logic    free
);

  assign free = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (free && push) begin
      dout <= din;
    end
  end

endmodule
